FILE: src/mpd_pkg.sv
// Shared types and constants for the packet deframer.
// Depends on nothing; every other file depends on it.
`default_nettype none

package mpd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'd1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'd117;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'd101;

  // Parser phases
  localparam logic [PHASE_W-1:0] PH_SYNC1 = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SYNC2 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DESC  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LEN   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CK1   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_CK2   = 3'd6;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_CSUM = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] item_kind;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_offset;
    logic [BYTE_W-1:0] desc_set;
    logic [BYTE_W-1:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

FILE: src/mpd_if.sv
// Channel interfaces of the packet deframer: received bytes, results, config writes.
// Depends on mpd_pkg for field widths.
`default_nettype none

interface mpd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [mpd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpd_result_if;
  logic                       valid;
  logic                       ready;
  logic [mpd_pkg::KIND_W-1:0] item_kind;
  logic [mpd_pkg::BYTE_W-1:0] data_byte;
  logic [mpd_pkg::BYTE_W-1:0] byte_offset;
  logic [mpd_pkg::BYTE_W-1:0] desc_set;
  logic [mpd_pkg::BYTE_W-1:0] frame_length;

  modport source (output valid, output item_kind, output data_byte, output byte_offset,
                  output desc_set, output frame_length, input ready);
  modport sink   (input valid, input item_kind, input data_byte, input byte_offset,
                  input desc_set, input frame_length, output ready);
endinterface

interface mpd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mpd_pkg::CFG_IDX_W-1:0] reg_index;
  logic [mpd_pkg::BYTE_W-1:0]    reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

FILE: src/mpd_parser.sv
// Frame parser: phase tracking, running checksums and result generation per byte.
// Depends on mpd_pkg.
`default_nettype none

module mpd_parser (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mpd_pkg::cfg_t               cfg,
  input  wire logic                        accept,
  input  wire logic [mpd_pkg::BYTE_W-1:0]  rx_byte,
  output logic                             res_valid,
  output mpd_pkg::result_t                 res
);
  import mpd_pkg::*;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [BYTE_W-1:0]  held_descriptor, held_descriptor_next;
  logic [BYTE_W-1:0]  held_length, held_length_next;
  logic [BYTE_W-1:0]  byte_count, byte_count_next;
  logic [BYTE_W-1:0]  sum_first, sum_first_next;
  logic [BYTE_W-1:0]  sum_second, sum_second_next;
  logic [BYTE_W-1:0]  first_check_byte, first_check_byte_next;

  logic [BYTE_W-1:0]  acc_first, acc_second;
  logic [BYTE_W:0]    count_inc;
  logic               produce;

  assign acc_first  = sum_first + rx_byte;
  assign acc_second = sum_second + acc_first;
  assign count_inc  = {1'b0, byte_count} + {{BYTE_W{1'b0}}, 1'b1};

  always_comb begin
    phase_next            = phase;
    held_descriptor_next  = held_descriptor;
    held_length_next      = held_length;
    byte_count_next       = byte_count;
    sum_first_next        = sum_first;
    sum_second_next       = sum_second;
    first_check_byte_next = first_check_byte;
    produce               = 1'b0;
    res.item_kind         = KIND_PAYLOAD;
    res.data_byte         = '0;
    res.byte_offset       = '0;
    res.desc_set          = held_descriptor;
    res.frame_length      = held_length;
    case (phase)
      PH_SYNC1: begin
        // Restart both sums on the first sync byte
        if (rx_byte == cfg.sync_first) begin
          sum_first_next  = rx_byte;
          sum_second_next = rx_byte;
          phase_next      = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == cfg.sync_second) begin
          sum_first_next  = acc_first;
          sum_second_next = acc_second;
          phase_next      = PH_DESC;
        end else begin
          phase_next = PH_SYNC1;
        end
      end
      PH_DESC: begin
        held_descriptor_next = rx_byte;
        sum_first_next       = acc_first;
        sum_second_next      = acc_second;
        phase_next           = PH_LEN;
      end
      PH_LEN: begin
        held_length_next = rx_byte;
        sum_first_next   = acc_first;
        sum_second_next  = acc_second;
        byte_count_next  = '0;
        // Skip the payload phase on an empty frame
        phase_next       = (rx_byte == '0) ? PH_CK1 : PH_DATA;
      end
      PH_DATA: begin
        sum_first_next  = acc_first;
        sum_second_next = acc_second;
        produce         = 1'b1;
        res.item_kind   = KIND_PAYLOAD;
        res.data_byte   = rx_byte;
        res.byte_offset = byte_count;
        if (count_inc >= {1'b0, held_length}) begin
          byte_count_next = '0;
          phase_next      = PH_CK1;
        end else begin
          byte_count_next = count_inc[BYTE_W-1:0];
        end
      end
      PH_CK1: begin
        first_check_byte_next = rx_byte;
        phase_next            = PH_CK2;
      end
      PH_CK2: begin
        produce       = 1'b1;
        res.item_kind = ((first_check_byte == sum_first) && (rx_byte == sum_second))
                        ? KIND_GOOD : KIND_BAD_CSUM;
        phase_next    = PH_SYNC1;
      end
      default: begin
        phase_next = PH_SYNC1;
      end
    endcase
  end

  assign res_valid = accept & produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SYNC1;
      held_descriptor  <= '0;
      held_length      <= '0;
      byte_count       <= '0;
      sum_first        <= '0;
      sum_second       <= '0;
      first_check_byte <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      held_descriptor  <= held_descriptor_next;
      held_length      <= held_length_next;
      byte_count       <= byte_count_next;
      sum_first        <= sum_first_next;
      sum_second       <= sum_second_next;
      first_check_byte <= first_check_byte_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/mpd_out_skid.sv
// Result register with a skid stage, so a new byte is taken while a result waits.
// Depends on mpd_pkg and mpd_if.
`default_nettype none

module mpd_out_skid (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire mpd_pkg::result_t push_data,
  output logic                  space,
  mpd_result_if.source          res
);
  import mpd_pkg::*;

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  // Accept upstream only while the skid slot is empty
  assign space = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res.ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign res.valid        = out_valid;
  assign res.item_kind    = out_data.item_kind;
  assign res.data_byte    = out_data.data_byte;
  assign res.byte_offset  = out_data.byte_offset;
  assign res.desc_set     = out_data.desc_set;
  assign res.frame_length = out_data.frame_length;

endmodule

`default_nettype wire

FILE: src/mip_packet_deframer_top.sv
// Top level of the packet deframer: config registers, parser and result buffer.
// Depends on mpd_pkg, mpd_if, mpd_parser and mpd_out_skid.
//
// Usage:
//   rx  : one received byte per item (rx_byte). The block hunts for the two
//         sync bytes, then takes descriptor set, length, payload and two
//         checksum bytes of each frame.
//   res : one item per payload byte (kind payload, data and offset) and one
//         verdict item per frame (kind good or checksum failed), each with
//         the frame's descriptor set and length. Drop the payload of a frame
//         whose verdict is bad.
//   cfg : writes the sync byte values (index 0 first, index 1 second). Always
//         ready; write only while no byte is in flight.
// Output: the result of an accepted byte is registered in the result buffer's
//   output register before it shows on res. Throughput: one byte per cycle
//   while rx.ready is high, set by the parser's per-byte phase and checksum update.
// Reset (rst, synchronous): sync values return to 117 and 101, the parser
//   returns to the first-sync hunt and the result buffer empties.
// Stall: while res is held off, one more result is parked in the skid stage;
//   rx.ready then drops until the waiting result is taken.
`default_nettype none

module mip_packet_deframer_top (
  input  wire logic    clk,
  input  wire logic    rst,
  mpd_byte_if.sink     rx,
  mpd_cfg_if.sink      cfg,
  mpd_result_if.source res
);
  import mpd_pkg::*;

  cfg_t    cfg_regs;
  logic    space;
  logic    accept;
  logic    res_valid;
  result_t res_data;

  // Configuration writes are always accepted and registered
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.sync_first  <= SYNC_FIRST_RESET;
      cfg_regs.sync_second <= SYNC_SECOND_RESET;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_SYNC_FIRST:  cfg_regs.sync_first  <= cfg.reg_data;
        REG_SYNC_SECOND: cfg_regs.sync_second <= cfg.reg_data;
        default: ;
      endcase
    end
  end

  // Take a byte whenever the result buffer has room for its result
  assign rx.ready = space;
  assign accept   = rx.valid & space;

  mpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .accept    (accept),
    .rx_byte   (rx.rx_byte),
    .res_valid (res_valid),
    .res       (res_data)
  );

  mpd_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .space     (space),
    .res       (res)
  );

endmodule

`default_nettype wire
